/* sv/seven_segment_number_frame_builder_macros.svh */
// Assertion macros for the seven-segment number frame builder.
// Included by the top level; no other dependencies.
`ifndef SEVEN_SEGMENT_NUMBER_FRAME_BUILDER_MACROS_SVH
`define SEVEN_SEGMENT_NUMBER_FRAME_BUILDER_MACROS_SVH
`ifndef SYNTH
`define SSNF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define SSNF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define SSNF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SSNF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/ssnf_pkg.sv */
// Shared types and constants of the seven-segment number frame builder.
// No dependencies.
`timescale 1ns / 1ps
package ssnf_pkg;

	localparam int NUM_DIGITS = 4;
	localparam int BYTES_PER_NUMBER = 20;
	localparam logic [7:0] BLANK_CODE = 8'h00;

	localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
	localparam logic [1:0] REG_FIXED_MODE = 2'd1;
	localparam logic [1:0] REG_ADDR_BASE  = 2'd2;
	localparam logic [1:0] REG_DISPLAY_ON = 2'd3;

	localparam logic [3:0] RST_BRIGHTNESS = 4'd4;
	localparam logic [7:0] RST_FIXED_MODE = 8'h44;
	localparam logic [7:0] RST_ADDR_BASE  = 8'hc0;
	localparam logic [7:0] RST_DISPLAY_ON = 8'h88;

	// common cathode, bit0 = a ... bit6 = g
	localparam logic [9:0][7:0] SEG_TABLE = {
		8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
	};

	typedef struct packed {
		logic [3:0] brightness_level;
		logic [7:0] fixed_mode_cmd;
		logic [7:0] address_base_cmd;
		logic [7:0] display_on_cmd;
	} cfg_t;

	// codes[0] is position 4 (ones) ... codes[3] is position 1 (thousands)
	typedef struct packed {
		logic                       valid;
		logic [NUM_DIGITS-1:0][7:0] codes;
	} digits_t;

	typedef struct packed {
		logic busy;
		logic load;
	} emit_stat_t;

endpackage

/* sv/ssnf_digit_pipe.sv */
// Decimal split and segment encoding pipeline: six stages, with the divide-by-ten steps in the middle stages.
// Depends on ssnf_pkg.
`timescale 1ns / 1ps
module ssnf_digit_pipe (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [15:0]          in_value,
	input  ssnf_pkg::emit_stat_t stat,
	output ssnf_pkg::digits_t    digits
);
	import ssnf_pkg::*;

	localparam logic [15:0] DIV10_MUL = 16'hcccd;
	localparam int DIV10_SHIFT = 19;

	// exact floor(x / 10) for any 16-bit x
	function automatic logic [15:0] div10(input logic [15:0] x);
		logic [31:0] p;
		p = {16'b0, x} * {16'b0, DIV10_MUL};
		return {3'b0, p[DIV10_SHIFT +: 13]};
	endfunction

	function automatic logic [3:0] rem10(input logic [15:0] x, input logic [15:0] q);
		logic [15:0] r;
		r = x - ((q << 3) + (q << 1));
		return r[3:0];
	endfunction

	function automatic logic [7:0] seg(input logic [3:0] d, input logic shown);
		logic [7:0] c;
		c = (d < 4'd10) ? SEG_TABLE[d] : BLANK_CODE;
		return shown ? c : BLANK_CODE;
	endfunction

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic [15:0] v_s1, v_s2;
	logic [12:0] q1_s2, q1_s3;
	logic [9:0]  q2_s3, q2_s4;
	logic [6:0]  q3_s4, q3_s5;
	logic [2:0]  q4_s5;
	logic [3:0]  d0_s3, d0_s4, d0_s5;
	logic [3:0]  d1_s4, d1_s5;
	logic [3:0]  d2_s5;
	// shown flags: [0] value > 9, [1] value > 99, [2] value > 999
	logic [2:0]  fl_s2, fl_s3, fl_s4, fl_s5;
	logic [NUM_DIGITS-1:0][7:0] codes_s6;

	logic [15:0] q1_n, q2_n, q3_n, q4_n;
	logic [3:0]  d3_n;

	assign adv      = !vld_s6 || stat.load;
	assign in_ready = adv;

	assign q1_n = div10(v_s1);
	assign q2_n = div10({3'b0, q1_s2});
	assign q3_n = div10({6'b0, q2_s3});
	assign q4_n = div10({9'b0, q3_s4});
	assign d3_n = rem10({9'b0, q3_s5}, {13'b0, q4_s5});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1 <= in_value;

			v_s2  <= v_s1;
			q1_s2 <= q1_n[12:0];
			fl_s2 <= {v_s1 > 16'd999, v_s1 > 16'd99, v_s1 > 16'd9};

			d0_s3 <= rem10(v_s2, {3'b0, q1_s2});
			q1_s3 <= q1_s2;
			q2_s3 <= q2_n[9:0];
			fl_s3 <= fl_s2;

			d0_s4 <= d0_s3;
			d1_s4 <= rem10({3'b0, q1_s3}, {6'b0, q2_s3});
			q2_s4 <= q2_s3;
			q3_s4 <= q3_n[6:0];
			fl_s4 <= fl_s3;

			d0_s5 <= d0_s4;
			d1_s5 <= d1_s4;
			d2_s5 <= rem10({6'b0, q2_s4}, {9'b0, q3_s4});
			q3_s5 <= q3_s4;
			q4_s5 <= q4_n[2:0];
			fl_s5 <= fl_s4;

			codes_s6[0] <= seg(d0_s5, 1'b1);
			codes_s6[1] <= seg(d1_s5, fl_s5[0]);
			codes_s6[2] <= seg(d2_s5, fl_s5[1]);
			codes_s6[3] <= seg(d3_n, fl_s5[2]);
		end
	end

	assign digits.valid = vld_s6;
	assign digits.codes = codes_s6;

endmodule

/* sv/ssnf_frame_emitter.sv */
// Frame sequencer: twenty bytes per number into a registered output beat.
// Depends on ssnf_pkg.
`timescale 1ns / 1ps
module ssnf_frame_emitter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ssnf_pkg::cfg_t       cfg,
	input  ssnf_pkg::digits_t    digits,
	output ssnf_pkg::emit_stat_t stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 out_start,
	output logic                 out_stop,
	output logic                 out_last
);
	import ssnf_pkg::*;

	localparam logic [1:0] SUB_MODE   = 2'd0;
	localparam logic [1:0] SUB_ADDR   = 2'd1;
	localparam logic [1:0] SUB_DATA   = 2'd2;
	localparam logic [1:0] SUB_BRIGHT = 2'd3;
	localparam logic [4:0] LAST_IDX   = 5'(BYTES_PER_NUMBER - 1);

	logic                       busy_q;
	logic [4:0]                 idx_q;
	logic [NUM_DIGITS-1:0][7:0] codes_q;
	logic                       valid_q, start_q, stop_q, last_q;
	logic [7:0]                 byte_q;

	logic       emit, load;
	logic [2:0] wr, wr_m1;
	logic [1:0] sub;
	logic [7:0] addr_n, bright_n, code_n, byte_n;
	logic       start_n, stop_n;

	assign emit = busy_q && (!valid_q || out_ready);
	assign load = !busy_q || (emit && idx_q == LAST_IDX);

	assign wr       = idx_q[4:2];
	assign sub      = idx_q[1:0];
	assign wr_m1    = wr - 3'd1;
	assign addr_n   = cfg.address_base_cmd + {5'b0, 3'd4 - wr};
	assign bright_n = cfg.display_on_cmd + {4'b0, cfg.brightness_level} - 8'd1;
	assign code_n   = (wr == 3'd0) ? BLANK_CODE : codes_q[wr_m1[1:0]];

	always_comb begin
		unique case (sub)
			SUB_MODE: begin
				byte_n  = cfg.fixed_mode_cmd;
				start_n = 1'b1;
				stop_n  = 1'b1;
			end
			SUB_ADDR: begin
				byte_n  = addr_n;
				start_n = 1'b1;
				stop_n  = 1'b0;
			end
			SUB_DATA: begin
				byte_n  = code_n;
				start_n = 1'b0;
				stop_n  = 1'b1;
			end
			SUB_BRIGHT: begin
				byte_n  = bright_n;
				start_n = 1'b1;
				stop_n  = 1'b1;
			end
			default: begin
				byte_n  = cfg.fixed_mode_cmd;
				start_n = 1'b1;
				stop_n  = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				busy_q <= digits.valid;
				idx_q  <= '0;
			end else if (emit) begin
				idx_q  <= idx_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q  <= byte_n;
			start_q <= start_n;
			stop_q  <= stop_n;
			last_q  <= (idx_q == LAST_IDX);
		end
		if (load && digits.valid) begin
			codes_q <= digits.codes;
		end
	end

	assign stat.busy = busy_q;
	assign stat.load = load;

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_start = start_q;
	assign out_stop  = stop_q;
	assign out_last  = last_q;

endmodule

/* sv/seven_segment_number_frame_builder.sv */
// Top level of the seven-segment number frame builder: config registers,
// digit pipeline and frame emitter. Depends on ssnf_pkg, both submodules and the macros header.
//
// Usage:
//   s_* stream: one beat carries a 16-bit number; its low four decimal digits
//   are shown, leading zeros blanked for values below 10000 (a lone zero shows as 0).
//   m_* stream: twenty byte beats per number, five fixed-address writes
//   (position 5 blank, then positions 4 to 1); tuser flags start and stop
//   conditions, tlast marks the twentieth byte.
//   cfg_*: write-only registers, to be written while the block is idle; the block leaves this to the user.
// Throughput: one output byte per cycle while a number is sent and m_tready is
// high, sequenced by the emitter's byte counter; the six-stage digit pipeline
// holds up to six further numbers when they arrive back to back while a
// sequence is sent.
// Reset: pipeline and emitter empty, registers at their defaults.
// Stall: a stalled output beat holds; the emitter waits, and the pipeline
// stops accepting as soon as its last stage holds a number the emitter
// cannot take yet, even if earlier stages are empty.
`timescale 1ns / 1ps
`include "seven_segment_number_frame_builder_macros.svh"
module seven_segment_number_frame_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] wire_byte
	output logic [1:0]  m_tuser,   // [0] starts_frame, [1] ends_frame
	output logic        m_tlast,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import ssnf_pkg::*;

	cfg_t       cfg_q;
	digits_t    digits;
	emit_stat_t stat;
	logic       starts, ends;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brightness_level <= RST_BRIGHTNESS;
			cfg_q.fixed_mode_cmd   <= RST_FIXED_MODE;
			cfg_q.address_base_cmd <= RST_ADDR_BASE;
			cfg_q.display_on_cmd   <= RST_DISPLAY_ON;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BRIGHTNESS: cfg_q.brightness_level <= cfg_data[3:0];
				REG_FIXED_MODE: cfg_q.fixed_mode_cmd   <= cfg_data;
				REG_ADDR_BASE:  cfg_q.address_base_cmd <= cfg_data;
				REG_DISPLAY_ON: cfg_q.display_on_cmd   <= cfg_data;
				default: ;
			endcase
		end
	end

	ssnf_digit_pipe u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_value (s_tdata),
		.stat     (stat),
		.digits   (digits)
	);

	ssnf_frame_emitter u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.digits    (digits),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_start (starts),
		.out_stop  (ends),
		.out_last  (m_tlast)
	);

	assign m_tuser = {ends, starts};

	// final beat of a sequence is always the brightness command frame
	`SSNF_ASSERT_IMPL(a_last_full_frame, clk, arst_n, m_tvalid && m_tlast, m_tuser[0] && m_tuser[1])
	// a number taken from the pipeline starts a sequence
	`SSNF_ASSERT_NEXT(a_load_sets_busy, clk, arst_n, stat.load && digits.valid, stat.busy)

endmodule
